// ===== hw/rtl/bloom_filter_double_hash_assert.svh =====
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH

// Property must hold at every edge out of reset
`define BFDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen out of reset
`define BFDH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/bfdh_pkg.sv =====
// ----------------------------------------------------------------------------
// Bloom filter package
// Operation codes, register indexes and the types passed between units.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int NB_W   = 17;   // filter size register width
  localparam int NH_W   = 7;    // probe count, room for up to 127
  localparam int HASH_W = 32;
  localparam int STEP_W = 47;   // widened step term before reduction
  localparam int CNT_W  = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_NUM_BITS   = 2'd0;
  localparam logic [1:0] CFG_NUM_HASHES = 2'd1;
  localparam logic [1:0] CFG_READY      = 2'd2;

  // One classified item waiting for the back end
  typedef struct packed {
    logic [1:0]        op;
    logic [HASH_W-1:0] hash;
    logic              usable;
    logic [NB_W-1:0]   nb;
    logic [NH_W-1:0]   nh;
  } item_t;

  // Head of the item queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic init_pass;
  } back_stat_t;

endpackage

// ===== hw/rtl/bloom_filter_double_hash.sv =====
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Insert, query and clear over a bit store probed by double hashing.
// ----------------------------------------------------------------------------
// Usage: drive in_operation and in_key_hash with start; the item is taken at
// an edge where start is high and busy is low. Each item gives one result,
// shown for one cycle with out_valid; the receiver cannot stall it.
// Registers are written on the cfg channel (index 0 filter size, 1 probe
// count, 2 filter_ready); the user must write them only while the block is
// idle, as the block itself does not enforce it; cfg_ready is always high.
// A usable insert or query makes two 47-step remainder passes in the shared
// one-bit-a-cycle remainder unit, then per probe a store read, then a check
// or a write back through the store's write port; a query stops at the first
// clear bit. An unusable item or unknown code is answered from the idle state
// without probing. A clear zeroes the store one byte row a cycle. A two-entry
// queue lets the front take items while the back is working. After reset the
// same clearing pass runs over all store rows (8192 by default) and busy
// stays high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash #(
  parameter int MAX_BITS   = 65536,
  parameter int MAX_HASHES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [bfdh_pkg::HASH_W-1:0] in_key_hash,
  output logic                        out_valid,
  output logic                        out_maybe_present,
  output logic                        out_status,
  output logic [bfdh_pkg::CNT_W-1:0]  out_insert_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [bfdh_pkg::NB_W-1:0]   cfg_data
);
  import bfdh_pkg::*;

`include "bloom_filter_double_hash_assert.svh"

  logic [NB_W-1:0] nb_r;
  logic [5:0]      nh_r;
  logic            rdy_r;
  queue_head_t     head;
  back_stat_t      bstat;
  logic            pop;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r  <= NB_W'(65536);
      nh_r  <= 6'd6;
      rdy_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_BITS:   nb_r  <= cfg_data;
        CFG_NUM_HASHES: nh_r  <= cfg_data[5:0];
        CFG_READY:      rdy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bfdh_front #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_key_hash (in_key_hash),
    .size_cfg    (nb_r),
    .probes_cfg  (nh_r),
    .filter_ready(rdy_r),
    .bstat       (bstat),
    .pop         (pop),
    .head        (head)
  );

  bfdh_back #(.MAX_BITS(MAX_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .bstat            (bstat),
    .out_valid        (out_valid),
    .out_maybe_present(out_maybe_present),
    .out_status       (out_status),
    .out_insert_count (out_insert_count)
  );

  // No result while the store is being swept after reset
  `BFDH_NEVER(a_no_out_in_init, out_valid && bstat.init_pass, "result during init sweep")
  // Back end never takes from an empty queue
  `BFDH_NEVER(a_pop_empty, pop && !head.valid, "pop from empty queue")
  // Insert count only steps by one or drops to zero
  `BFDH_ASSERT(a_cnt_step, (out_insert_count != $past(out_insert_count)) |-> (out_insert_count == $past(out_insert_count) + 32'd1 || out_insert_count == 32'd0), "insert count jumped")

endmodule

// ===== hw/rtl/bfdh_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bfdh_div.sv =====
// ----------------------------------------------------------------------------
// Bloom filter remainder unit
// Restoring remainder of a 47-bit value by the filter size, one bit a cycle.
// ----------------------------------------------------------------------------
module bfdh_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [bfdh_pkg::STEP_W-1:0] num,
  input  logic [bfdh_pkg::NB_W-1:0]  den,
  output logic                       done,
  output logic [bfdh_pkg::NB_W-1:0]  rem
);
  import bfdh_pkg::*;

  logic [STEP_W-1:0] sh_r, sh_nxt;
  logic [NB_W-1:0]   rem_r, rem_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [NB_W:0]     trial;

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem_r, sh_r[STEP_W-1]};
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      sh_nxt  = num;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      sh_nxt  = {sh_r[STEP_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt = NB_W'(trial - {1'b0, den});
      end else begin
        rem_nxt = NB_W'(trial);
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(STEP_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/bfdh_front.sv =====
// ----------------------------------------------------------------------------
// Bloom filter front end
// Accepts items, classifies them against the registers and queues them.
// ----------------------------------------------------------------------------
module bfdh_front #(
  parameter int MAX_BITS   = 65536,
  parameter int MAX_HASHES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [bfdh_pkg::HASH_W-1:0] in_key_hash,
  input  logic [bfdh_pkg::NB_W-1:0]   size_cfg,
  input  logic [5:0]                  probes_cfg,
  input  logic                        filter_ready,
  input  bfdh_pkg::back_stat_t        bstat,
  input  logic                        pop,
  output bfdh_pkg::queue_head_t       head
);
  import bfdh_pkg::*;

  item_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls;

  // Clamp the registers and decide whether the filter may be used
  always_comb begin
    cls.op   = in_operation;
    cls.hash = in_key_hash;
    if ({15'd0, size_cfg} > 32'(MAX_BITS)) begin
      cls.nb = NB_W'(MAX_BITS);
    end else begin
      cls.nb = size_cfg;
    end
    if ({1'b0, probes_cfg} > NH_W'(MAX_HASHES)) begin
      cls.nh = NH_W'(MAX_HASHES);
    end else begin
      cls.nh = {1'b0, probes_cfg};
    end
    cls.usable = filter_ready && (cls.nb != '0) && (cls.nh != '0);
  end

  assign busy = (cnt_r == 2'd2) || bstat.init_pass;
  assign push = start && !busy;

  // Advance queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

endmodule

// ===== hw/rtl/bfdh_back.sv =====
// ----------------------------------------------------------------------------
// Bloom filter back end
// Reduces probe positions, walks the probes through the bit store, clears.
// ----------------------------------------------------------------------------
module bfdh_back #(
  parameter int MAX_BITS = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfdh_pkg::queue_head_t      head,
  output logic                       pop,
  output bfdh_pkg::back_stat_t       bstat,
  output logic                       out_valid,
  output logic                       out_maybe_present,
  output logic                       out_status,
  output logic [bfdh_pkg::CNT_W-1:0] out_insert_count
);
  import bfdh_pkg::*;

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIVP = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_CHK  = 3'd5;

  logic [2:0]       st_r, st_nxt;
  item_t            it_r, it_nxt;
  logic             init_r, init_nxt;
  logic [AW-1:0]    ca_r, ca_nxt;
  logic [NB_W-1:0]  pos_r, pos_nxt, step_r, step_nxt;
  logic [NH_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt, om_r, om_nxt, os_r, os_nxt;
  logic [CNT_W-1:0] oc_r, oc_nxt;

  logic              div_go, div_done;
  logic [STEP_W-1:0] div_num;
  logic [NB_W-1:0]   div_rem;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, rdata, mask;
  logic [NB_W:0]     sum;
  logic              last;

  bfdh_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (it_r.nb),
    .done (div_done),
    .rem  (div_rem)
  );

  bfdh_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign mask  = 8'd1 << pos_r[2:0];
  assign sum   = {1'b0, pos_r} + {1'b0, step_r};
  assign last  = (idx_r + NH_W'(1)) == it_r.nh;
  assign raddr = AW'(pos_r >> 3);

  // Sequence one item at a time
  always_comb begin
    st_nxt   = st_r;
    it_nxt   = it_r;
    init_nxt = init_r;
    ca_nxt   = ca_r;
    pos_nxt  = pos_r;
    step_nxt = step_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = 1'b0;
    om_nxt   = om_r;
    os_nxt   = os_r;
    oc_nxt   = oc_r;
    pop      = 1'b0;
    div_go   = 1'b0;
    div_num  = {15'd0, head.item.hash};
    we       = 1'b0;
    waddr    = raddr;
    wdata    = rdata | mask;
    case (st_r)
      ST_CLR: begin
        // Zero one row a cycle
        we      = 1'b1;
        waddr   = ca_r;
        wdata   = '0;
        cnt_nxt = '0;
        ca_nxt  = ca_r + AW'(1);
        if (ca_r == AW'(DEPTH - 1)) begin
          st_nxt   = ST_IDLE;
          init_nxt = 1'b0;
          if (!init_r) begin
            ov_nxt = 1'b1;
            om_nxt = 1'b0;
            os_nxt = !it_r.usable;
            oc_nxt = '0;
          end
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop    = 1'b1;
          it_nxt = head.item;
          if (head.item.op == OP_CLEAR) begin
            st_nxt = ST_CLR;
            ca_nxt = '0;
          end else if (head.item.usable &&
                       (head.item.op == OP_INSERT || head.item.op == OP_QUERY)) begin
            div_go = 1'b1;
            st_nxt = ST_DIVP;
          end else begin
            // Unknown code or unusable filter: answer at once
            ov_nxt = 1'b1;
            om_nxt = (head.item.op == OP_QUERY);
            os_nxt = !head.item.usable;
            oc_nxt = cnt_r;
          end
        end
      end
      ST_DIVP: begin
        div_num = {it_r.hash, 15'd0} | {32'd0, it_r.hash[31:17]};
        if (div_done) begin
          pos_nxt = div_rem;
          div_go  = 1'b1;
          st_nxt  = ST_DIVS;
        end
      end
      ST_DIVS: begin
        if (div_done) begin
          step_nxt = div_rem;
          idx_nxt  = '0;
          st_nxt   = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_CHK;
      end
      ST_CHK: begin
        // Set or test the probed bit, then advance to the next probe
        if (sum >= {1'b0, it_r.nb}) begin
          pos_nxt = NB_W'(sum - {1'b0, it_r.nb});
        end else begin
          pos_nxt = NB_W'(sum);
        end
        idx_nxt = idx_r + NH_W'(1);
        st_nxt  = ST_RD;
        if (it_r.op == OP_INSERT) begin
          we = 1'b1;
          if (last) begin
            st_nxt = ST_IDLE;
            ov_nxt = 1'b1;
            om_nxt = 1'b0;
            os_nxt = 1'b0;
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + CNT_W'(1);
              oc_nxt  = cnt_r + CNT_W'(1);
            end else begin
              oc_nxt = cnt_r;
            end
          end
        end else if ((rdata & mask) == 8'd0 || last) begin
          st_nxt = ST_IDLE;
          ov_nxt = 1'b1;
          om_nxt = ((rdata & mask) != 8'd0);
          os_nxt = 1'b0;
          oc_nxt = cnt_r;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      init_r <= 1'b1;
      ca_r   <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      init_r <= init_nxt;
      ca_r   <= ca_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
    it_r   <= it_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    om_r   <= om_nxt;
    os_r   <= os_nxt;
    oc_r   <= oc_nxt;
  end

  assign bstat.init_pass   = init_r;
  assign out_valid         = ov_r;
  assign out_maybe_present = om_r;
  assign out_status        = os_r;
  assign out_insert_count  = oc_r;

endmodule

// ===== bench/bloom_filter_double_hash_checker.sv =====
// ----------------------------------------------------------------------------
// Bloom filter result checker
// Watches the register, item and result channels, keeps its own copy of the
// filter bits and insert counter, and compares each result with the oldest
// expected answer.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_checker #(
  parameter int MAX_BITS   = 65536,
  parameter int MAX_HASHES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [bfdh_pkg::HASH_W-1:0] in_key_hash,
  input  logic                        out_valid,
  input  logic                        out_maybe_present,
  input  logic                        out_status,
  input  logic [bfdh_pkg::CNT_W-1:0]  out_insert_count,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [bfdh_pkg::NB_W-1:0]   cfg_data,
  output int                          fail_count,
  output int                          answers_pending,
  output int                          items_seen,
  output int                          answers_seen,
  output int                          hits_seen
);
  import bfdh_pkg::*;

  typedef struct packed {
    logic             maybe_present;
    logic             status;
    logic [CNT_W-1:0] insert_count;
  } answer_t;

  bit              filter_bit [MAX_BITS];
  logic [CNT_W-1:0] keys_inserted;
  logic [16:0]     reg_size;
  logic [5:0]      reg_probes;
  logic            reg_ready;
  answer_t         answer_q [$];

  assign answers_pending = answer_q.size();

  // Wipe the filter bits and the insert counter
  task automatic wipe_filter();
    foreach (filter_bit[i]) filter_bit[i] = 1'b0;
    keys_inserted = '0;
  endtask

  // Apply one item to the filter copy and return the answer it gives
  task automatic apply_item(input logic [1:0] op, input logic [31:0] hash,
                            output answer_t ans);
    longint unsigned nb, nh, step, pos, h;
    bit usable;
    nb = 64'(reg_size);
    nh = 64'(reg_probes);
    h  = 64'(hash);
    if (nb > 64'(MAX_BITS)) nb = 64'(MAX_BITS);
    if (nh > 64'(MAX_HASHES)) nh = 64'(MAX_HASHES);
    usable = reg_ready && nb != 0 && nh != 0;
    ans.maybe_present = 1'b0;
    ans.status = !usable;
    if (op == OP_CLEAR) begin
      wipe_filter();
    end else if (op == OP_INSERT || op == OP_QUERY) begin
      if (!usable) begin
        ans.maybe_present = (op == OP_QUERY);
      end else begin
        // Double hashing: start at hash mod nb, advance by the 47-bit step term mod nb
        step = ((h >> 17) | (h << 15)) % nb;
        pos  = h % nb;
        ans.maybe_present = (op == OP_QUERY);
        for (longint unsigned k = 0; k < nh; k++) begin
          if (op == OP_INSERT) begin
            filter_bit[pos] = 1'b1;
          end else if (!filter_bit[pos]) begin
            ans.maybe_present = 1'b0;
            break;
          end
          pos += step;
          if (pos >= nb) pos -= nb;
        end
        if (op == OP_INSERT && keys_inserted != '1) keys_inserted++;
      end
    end
    ans.insert_count = keys_inserted;
  endtask

  always @(posedge clk) begin
    answer_t exp_ans;
    answer_t got_ans;
    int      errs;
    if (!rst_n) begin
      wipe_filter();
      reg_size     <= 17'd65536;
      reg_probes   <= 6'd6;
      reg_ready    <= 1'b0;
      answer_q.delete();
      fail_count   <= 0;
      items_seen   <= 0;
      answers_seen <= 0;
      hits_seen    <= 0;
    end else begin
      errs = 0;
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_BITS:   reg_size   <= cfg_data;
          CFG_NUM_HASHES: reg_probes <= cfg_data[5:0];
          CFG_READY:      reg_ready  <= cfg_data[0];
          default: ;
        endcase
      end
      // Compare each result with the oldest expected answer
      if (out_valid) begin
        answers_seen <= answers_seen + 1;
        got_ans = '{out_maybe_present, out_status, out_insert_count};
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, got_ans);
          errs++;
        end else begin
          exp_ans = answer_q.pop_front();
          if (got_ans.maybe_present && !got_ans.status) hits_seen <= hits_seen + 1;
          if (got_ans.maybe_present !== exp_ans.maybe_present) begin
            $display("%0t: maybe_present mismatch: expected %0b, actual %0b",
                     $time, exp_ans.maybe_present, got_ans.maybe_present);
            errs++;
          end
          if (got_ans.status !== exp_ans.status) begin
            $display("%0t: status mismatch: expected %0b, actual %0b",
                     $time, exp_ans.status, got_ans.status);
            errs++;
          end
          if (got_ans.insert_count !== exp_ans.insert_count) begin
            $display("%0t: insert_count mismatch: expected %0d, actual %0d",
                     $time, exp_ans.insert_count, got_ans.insert_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      // Predict the answer of each accepted item (registers are stable here)
      if (start && !busy) begin
        apply_item(in_operation, in_key_hash, exp_ans);
        answer_q.push_back(exp_ans);
        items_seen <= items_seen + 1;
      end
    end
  end

endmodule

// ===== bench/bloom_filter_double_hash_test.sv =====
// ----------------------------------------------------------------------------
// Bloom filter testbench
// Drives directed and random insert, query, clear and unknown-code items
// through a range of filter sizes and probe counts, with random idle
// bursts, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_test;
  import bfdh_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_operation = OP_INSERT;
  logic [HASH_W-1:0] in_key_hash = '0;
  logic              out_valid;
  logic              out_maybe_present;
  logic              out_status;
  logic [CNT_W-1:0]  out_insert_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_NUM_BITS;
  logic [NB_W-1:0]   cfg_data = '0;

  int fail_count, answers_pending, items_seen, answers_seen, hits_seen;
  bit quiet = 1'b0;
  int phases_run = 0;
  logic [31:0] known_keys [$];

  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  bloom_filter_double_hash u_dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_key_hash,
    .out_valid, .out_maybe_present, .out_status, .out_insert_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  bloom_filter_double_hash_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_operation, .in_key_hash,
    .out_valid, .out_maybe_present, .out_status, .out_insert_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .answers_pending, .items_seen, .answers_seen, .hits_seen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Send one item; returns at the edge that accepts it
  task automatic send_item(input logic [1:0] op, input logic [31:0] hash);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_key_hash  <= hash;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (op == OP_INSERT) known_keys.push_back(hash);
    if (op == OP_CLEAR) known_keys.delete();
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [NB_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all results, then let the back end settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (answers_pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_filter(input logic [NB_W-1:0] nb, input logic [NB_W-1:0] nh,
                            input logic rdy);
    drain();
    write_reg(CFG_NUM_BITS, nb);
    write_reg(CFG_NUM_HASHES, nh);
    write_reg(CFG_READY, {16'd0, rdy});
    phases_run++;
  endtask

  // Pick a random item, leaning on keys already inserted
  task automatic random_item();
    int pick;
    logic [31:0] hash;
    pick = $urandom_range(0, 99);
    hash = $urandom();
    if (pick < 40) begin
      send_item(OP_INSERT, hash);
    end else if (pick < 95) begin
      if (known_keys.size() != 0 && $urandom_range(0, 9) < 7)
        hash = known_keys[$urandom_range(0, known_keys.size() - 1)];
      send_item(OP_QUERY, hash);
    end else if (pick < 97) begin
      send_item(OP_CLEAR, hash);
    end else begin
      send_item(OP_UNKNOWN, hash);
    end
  endtask

  initial begin
    logic [NB_W-1:0] nb, nh;
    int sel;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Not ready after reset: every code reports an error
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_QUERY, 32'hFFFF_FFFF);
    send_item(OP_UNKNOWN, 32'h1234_5678);
    send_item(OP_CLEAR, 32'h0);

    // Default size, ready: hash extremes, hit, miss, unknown code, clear
    set_filter(17'd65536, 17'd6, 1'b1);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'h0000_0000);
    send_item(OP_QUERY, 32'h8000_0001);
    send_item(OP_UNKNOWN, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'hFFFF_FFFF);

    // Smallest filter and single probe
    set_filter(17'd1, 17'd1, 1'b1);
    send_item(OP_QUERY, 32'hDEAD_BEEF);
    send_item(OP_INSERT, 32'hDEAD_BEEF);
    send_item(OP_QUERY, 32'h0000_0001);

    // Oversized registers saturate to the largest filter and probe count
    set_filter(17'h1FFFF, 17'd63, 1'b1);
    send_item(OP_INSERT, 32'hA5A5_5A5A);
    send_item(OP_QUERY, 32'hA5A5_5A5A);
    send_item(OP_QUERY, 32'h5A5A_A5A5);

    // Zero size or zero probes make the filter unusable
    set_filter(17'd0, 17'd32, 1'b1);
    send_item(OP_INSERT, 32'h1);
    send_item(OP_QUERY, 32'h1);
    set_filter(17'd64, 17'd0, 1'b1);
    send_item(OP_QUERY, 32'h2);
    send_item(OP_CLEAR, 32'h2);

    // Random phases over a spread of settings
    for (int ph = 0; ph < 12; ph++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       nb = 17'd1;
        1, 2:    nb = NB_W'($urandom_range(2, 64));
        3, 4:    nb = NB_W'($urandom_range(65, 4096));
        5:       nb = 17'd65536;
        6:       nb = NB_W'($urandom_range(65537, 17'h1FFFF));
        default: nb = NB_W'($urandom_range(1, 65536));
      endcase
      nh = ($urandom_range(0, 4) == 0) ? NB_W'($urandom_range(33, 63))
                                       : NB_W'($urandom_range(1, 32));
      if (ph == 3) nh = 17'd0;
      if (ph == 7) nb = 17'd0;
      if (ph >= 10) quiet = 1'b1;
      set_filter(nb, nh, (ph != 5));
      if (ph == 1) write_reg(CFG_READY, 17'h1FFFE);
      repeat (145) random_item();
    end

    drain();
    repeat (300) @(posedge clk);
    $display("Covered %0d items and %0d results over %0d register settings;",
             items_seen, answers_seen, phases_run);
    $display("%0d queries answered maybe-present on a usable filter.", hits_seen);
    if (answers_pending != 0)
      $display("%0t: %0d expected results never arrived", $time, answers_pending);
    if (fail_count == 0 && answers_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #1000000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== bloom_filter_double_hash.f =====
+incdir+hw/rtl
hw/rtl/bfdh_pkg.sv
hw/rtl/bfdh_ram.sv
hw/rtl/bfdh_div.sv
hw/rtl/bfdh_front.sv
hw/rtl/bfdh_back.sv
hw/rtl/bloom_filter_double_hash.sv
bench/bloom_filter_double_hash_checker.sv
bench/bloom_filter_double_hash_test.sv
